[rtl/core/audio_level_and_pitch_meter_defines.svh]
// ----------------------------------------------------------------------------
// Audio level and pitch meter assertion macros
// Concurrent assertion wrappers; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef AUDIO_LEVEL_AND_PITCH_METER_DEFINES_SVH
`define AUDIO_LEVEL_AND_PITCH_METER_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on the rising clock edge, off while reset is high
`define ALPM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// property checked on every rising clock edge, reset included
`define ALPM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ALPM_ASSERT(label, clk, rst, prop)
`define ALPM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[rtl/core/alpm_pkg.sv]
// ----------------------------------------------------------------------------
// Audio level and pitch meter package
// Widths, register map, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package alpm_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int MAX_FRAME_LOG2 = 12;
   localparam int MIN_FRAME_LOG2 = 4;

   localparam int LG_BITS     = 4;
   localparam int RATE_BITS   = 17;
   localparam int WEIGHT_BITS = 16;
   localparam int ACC_FRAC    = 8;
   localparam int OUT_BITS    = 16;
   localparam int ACC_BITS    = OUT_BITS + ACC_FRAC;

   localparam int SQ_BITS    = 2 * SAMPLE_BITS - 1;
   localparam int SUM_BITS   = 2 * SAMPLE_BITS - 2 + MAX_FRAME_LOG2;
   localparam int IDX_BITS   = MAX_FRAME_LOG2;
   localparam int CROSS_BITS = MAX_FRAME_LOG2 + 1;

   localparam int RAD_BITS  = SUM_BITS - MIN_FRAME_LOG2;
   localparam int ROOT_BITS = (RAD_BITS + 1) / 2;
   localparam int RAD_PAD   = 2 * ROOT_BITS;
   localparam int REM_BITS  = ROOT_BITS + 1;
   localparam int CNT_BITS  = $clog2(ROOT_BITS);

   localparam int PROD_BITS  = CROSS_BITS + RATE_BITS;
   localparam int PITCH_BITS = PROD_BITS - MIN_FRAME_LOG2 - 1;
   localparam int X_BITS     = (PITCH_BITS > ROOT_BITS) ? PITCH_BITS : ROOT_BITS;

   localparam int CW_BITS = WEIGHT_BITS + 1;
   localparam int ONE_W   = 1 << WEIGHT_BITS;
   localparam int ROUND_W = 1 << (WEIGHT_BITS - 1);
   localparam int PA_BITS = CW_BITS + ACC_BITS;
   localparam int PB_BITS = WEIGHT_BITS + X_BITS;
   localparam int T_BITS  = ((PA_BITS > PB_BITS + ACC_FRAC) ? PA_BITS : PB_BITS + ACC_FRAC) + 1;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;

   localparam int RESET_FRAME_LEN_LOG2 = 8;
   localparam int RESET_SAMPLE_RATE    = 44100;
   localparam int RESET_FAST_WEIGHT    = 6554;
   localparam int RESET_SLOW_WEIGHT    = 655;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [1:0] {
      REG_FRAME_LEN_LOG2,
      REG_SAMPLE_RATE,
      REG_FAST_WEIGHT,
      REG_SLOW_WEIGHT
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_FLUSH,
      ST_LOAD,
      ST_SQRT,
      ST_AVG_MUL,
      ST_AVG_ADD,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      AVG_LEVEL_FAST,
      AVG_LEVEL_SLOW,
      AVG_PITCH_FAST,
      AVG_PITCH_SLOW
   } avg_sel_type;

   typedef struct packed {
      logic [LG_BITS-1:0]     frame_len_log2;
      logic [RATE_BITS-1:0]   sample_rate;
      logic [WEIGHT_BITS-1:0] fast_weight;
      logic [WEIGHT_BITS-1:0] slow_weight;
   } cfg_type;

   typedef struct packed {
      logic        accept;
      logic        load;
      logic        sqrt_step;
      logic        avg_mul;
      logic        avg_add;
      avg_sel_type avg_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic frame_end;
   } status_type;

endpackage

[rtl/core/alpm_if.sv]
// ----------------------------------------------------------------------------
// Audio level and pitch meter channels
// Valid/ready request channel of samples and response channel of results.
// ----------------------------------------------------------------------------
interface alpm_req_if;
   import alpm_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface alpm_rsp_if;
   import alpm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OUT_BITS-1:0]     rms_level;
   logic [OUT_BITS-1:0]     level_fast;
   logic [OUT_BITS-1:0]     level_slow;
   logic [CROSS_BITS-1:0]   crossing_count;
   logic [OUT_BITS-1:0]     pitch_fast;
   logic [OUT_BITS-1:0]     pitch_slow;

   modport source (
      output valid, output rms_level, output level_fast, output level_slow,
      output crossing_count, output pitch_fast, output pitch_slow, input ready
   );
   modport sink (
      input valid, input rms_level, input level_fast, input level_slow,
      input crossing_count, input pitch_fast, input pitch_slow, output ready
   );
endinterface

[rtl/core/audio_level_and_pitch_meter.sv]
// ----------------------------------------------------------------------------
// Audio level and pitch meter
// RMS level, zero-crossing count, pitch estimate and their smoothed averages.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a frame fills. After the last sample
// of a frame of 2^frame_len_log2 samples (exponent clamped to 4..12) the
// request side stalls while the final square is added, the frame is latched,
// the square root is formed (one root bit per cycle through a single
// restoring stage), the four averages go through one shared pair of
// multipliers and the response register is written, plus any wait for that
// register to be freed. The square root loop sets most of the overhead. The
// response register lets the next frame fill while a result waits.
// Configuration writes belong between frames or while no sample is pending.
module audio_level_and_pitch_meter (
   input  logic                                clock,
   input  logic                                reset,
   alpm_req_if.sink                            req_ch,
   alpm_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [alpm_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [alpm_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [alpm_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);
   import alpm_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   alpm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   alpm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .sample         (req_ch.sample),
      .rms_level      (rsp_ch.rms_level),
      .level_fast     (rsp_ch.level_fast),
      .level_slow     (rsp_ch.level_slow),
      .crossing_count (rsp_ch.crossing_count),
      .pitch_fast     (rsp_ch.pitch_fast),
      .pitch_slow     (rsp_ch.pitch_slow)
   );

   alpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

endmodule

[rtl/core/alpm_csr.sv]
// ----------------------------------------------------------------------------
// Audio level and pitch meter register file
// APB-style configuration registers: frame length, sample rate, weights.
// ----------------------------------------------------------------------------
module alpm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [alpm_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [alpm_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [alpm_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output alpm_pkg::cfg_type                   cfg
);
   import alpm_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write;

   assign index  = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign write  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (index)
            REG_FRAME_LEN_LOG2: cfg_in.frame_len_log2 = pwdata[LG_BITS-1:0];
            REG_SAMPLE_RATE:    cfg_in.sample_rate    = pwdata[RATE_BITS-1:0];
            REG_FAST_WEIGHT:    cfg_in.fast_weight    = pwdata[WEIGHT_BITS-1:0];
            REG_SLOW_WEIGHT:    cfg_in.slow_weight    = pwdata[WEIGHT_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_FRAME_LEN_LOG2: prdata = CSR_DATA_BITS'(cfg_ff.frame_len_log2);
         REG_SAMPLE_RATE:    prdata = CSR_DATA_BITS'(cfg_ff.sample_rate);
         REG_FAST_WEIGHT:    prdata = CSR_DATA_BITS'(cfg_ff.fast_weight);
         REG_SLOW_WEIGHT:    prdata = CSR_DATA_BITS'(cfg_ff.slow_weight);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_len_log2 <= LG_BITS'(RESET_FRAME_LEN_LOG2);
         cfg_ff.sample_rate    <= RATE_BITS'(RESET_SAMPLE_RATE);
         cfg_ff.fast_weight    <= WEIGHT_BITS'(RESET_FAST_WEIGHT);
         cfg_ff.slow_weight    <= WEIGHT_BITS'(RESET_SLOW_WEIGHT);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/alpm_datapath.sv]
// ----------------------------------------------------------------------------
// Audio level and pitch meter datapath
// Square sum, crossing count, bit-serial square root, shared average unit.
// ----------------------------------------------------------------------------
module alpm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  alpm_pkg::cfg_type                    cfg,
   input  alpm_pkg::cmd_type                    cmd,
   output alpm_pkg::status_type                 status,
   input  alpm_pkg::sample_type                 sample,
   output logic [alpm_pkg::OUT_BITS-1:0]        rms_level,
   output logic [alpm_pkg::OUT_BITS-1:0]        level_fast,
   output logic [alpm_pkg::OUT_BITS-1:0]        level_slow,
   output logic [alpm_pkg::CROSS_BITS-1:0]      crossing_count,
   output logic [alpm_pkg::OUT_BITS-1:0]        pitch_fast,
   output logic [alpm_pkg::OUT_BITS-1:0]        pitch_slow
);
   import alpm_pkg::*;

   // frame state
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [CROSS_BITS-1:0] cross_ff, cross_in;
   logic                  last_pos_ff, last_pos_in;
   logic [SQ_BITS-1:0]    sq_ff, sq_in;
   logic                  sq_pend_ff, sq_pend_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [ACC_BITS-1:0]   acc_ff [4];
   logic [ACC_BITS-1:0]   acc_in [4];

   // end of frame work
   logic [RAD_PAD-1:0]    rad_ff, rad_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [CROSS_BITS-1:0] fcross_ff, fcross_in;
   logic [PROD_BITS-1:0]  pmul_ff, pmul_in;
   logic [PITCH_BITS-1:0] pitch_ff, pitch_in;
   logic [PA_BITS-1:0]    pa_ff, pa_in;
   logic [PB_BITS-1:0]    pb_ff, pb_in;

   // response payload
   logic [OUT_BITS-1:0]   rms_ff, rms_in;
   logic [OUT_BITS-1:0]   lf_ff, lf_in;
   logic [OUT_BITS-1:0]   ls_ff, ls_in;
   logic [CROSS_BITS-1:0] co_ff, co_in;
   logic [OUT_BITS-1:0]   pf_ff, pf_in;
   logic [OUT_BITS-1:0]   ps_ff, ps_in;

   logic [LG_BITS-1:0]       lg;
   logic [IDX_BITS:0]        len_w;
   logic [IDX_BITS-1:0]      len_m1;
   logic [SAMPLE_BITS-1:0]   raw;
   logic [SAMPLE_BITS-1:0]   mag;
   logic                     positive;
   logic [2*SAMPLE_BITS-1:0] sq_full;
   logic [SUM_BITS:0]        sum_add;
   logic [REM_BITS+1:0]      rem_sh;
   logic [REM_BITS+1:0]      trial;
   logic [LG_BITS:0]         pshift;
   logic [WEIGHT_BITS-1:0]   w;
   logic [CW_BITS-1:0]       cw;
   logic [X_BITS-1:0]        x;
   logic [T_BITS-1:0]        t;

   always_comb begin
      if (cfg.frame_len_log2 < LG_BITS'(MIN_FRAME_LOG2)) begin
         lg = LG_BITS'(MIN_FRAME_LOG2);
      end else if (cfg.frame_len_log2 > LG_BITS'(MAX_FRAME_LOG2)) begin
         lg = LG_BITS'(MAX_FRAME_LOG2);
      end else begin
         lg = cfg.frame_len_log2;
      end
   end

   assign len_w            = (IDX_BITS + 1)'(1) << lg;
   assign len_m1           = IDX_BITS'(len_w - 1'b1);
   assign status.frame_end = (idx_ff >= len_m1);

   assign raw      = SAMPLE_BITS'(sample);
   assign mag      = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + 1'b1) : raw;
   assign positive = !raw[SAMPLE_BITS-1] && (raw != '0);
   assign sq_full  = (2 * SAMPLE_BITS)'(mag) * (2 * SAMPLE_BITS)'(mag);
   assign sum_add  = {1'b0, sum_ff} + (SUM_BITS + 1)'(sq_ff);

   assign rem_sh = {rem_ff, rad_ff[RAD_PAD-1 -: 2]};
   assign trial  = (REM_BITS + 2)'({root_ff, 2'b01});
   assign pshift = (LG_BITS + 1)'(lg) + 1'b1;

   always_comb begin
      case (cmd.avg_sel)
         AVG_LEVEL_FAST: begin w = cfg.fast_weight; x = X_BITS'(root_ff); end
         AVG_LEVEL_SLOW: begin w = cfg.slow_weight; x = X_BITS'(root_ff); end
         AVG_PITCH_FAST: begin w = cfg.fast_weight; x = X_BITS'(pitch_ff); end
         default:        begin w = cfg.slow_weight; x = X_BITS'(pitch_ff); end
      endcase
   end

   assign cw = CW_BITS'(ONE_W) - CW_BITS'(w);
   assign t  = T_BITS'(pa_ff) + (T_BITS'(pb_ff) << ACC_FRAC) + T_BITS'(ROUND_W);

   always_comb begin
      idx_in      = idx_ff;
      cross_in    = cross_ff;
      last_pos_in = last_pos_ff;
      sq_in       = sq_ff;
      sq_pend_in  = 1'b0;
      sum_in      = sum_ff;
      acc_in      = acc_ff;
      rad_in      = rad_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      fcross_in   = fcross_ff;
      pmul_in     = pmul_ff;
      pitch_in    = pitch_ff;
      pa_in       = pa_ff;
      pb_in       = pb_ff;
      rms_in      = rms_ff;
      lf_in       = lf_ff;
      ls_in       = ls_ff;
      co_in       = co_ff;
      pf_in       = pf_ff;
      ps_in       = ps_ff;

      // square is registered, added in the following cycle
      if (sq_pend_ff) begin
         sum_in = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
      end

      if (cmd.accept) begin
         sq_in       = sq_full[SQ_BITS-1:0];
         sq_pend_in  = 1'b1;
         last_pos_in = positive;
         if (positive != last_pos_ff) begin
            cross_in = cross_ff + 1'b1;
         end
         idx_in = status.frame_end ? '0 : idx_ff + 1'b1;
      end

      if (cmd.load) begin
         rad_in    = RAD_PAD'(RAD_BITS'(sum_ff >> lg));
         rem_in    = '0;
         root_in   = '0;
         fcross_in = cross_ff;
         pmul_in   = PROD_BITS'(cross_ff) * PROD_BITS'(cfg.sample_rate);
         sum_in    = '0;
         cross_in  = '0;
      end

      // one root bit per step
      if (cmd.sqrt_step) begin
         rad_in   = rad_ff << 2;
         pitch_in = PITCH_BITS'(pmul_ff >> pshift);
         if (rem_sh >= trial) begin
            rem_in  = REM_BITS'(rem_sh - trial);
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = REM_BITS'(rem_sh);
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end

      if (cmd.avg_mul) begin
         pa_in = PA_BITS'(cw) * PA_BITS'(acc_ff[cmd.avg_sel]);
         pb_in = PB_BITS'(w) * PB_BITS'(x);
      end

      if (cmd.avg_add) begin
         acc_in[cmd.avg_sel] = t[ACC_BITS+WEIGHT_BITS-1:WEIGHT_BITS];
      end

      if (cmd.out_load) begin
         rms_in = OUT_BITS'(root_ff);
         lf_in  = acc_ff[AVG_LEVEL_FAST][ACC_BITS-1:ACC_FRAC];
         ls_in  = acc_ff[AVG_LEVEL_SLOW][ACC_BITS-1:ACC_FRAC];
         co_in  = fcross_ff;
         pf_in  = acc_ff[AVG_PITCH_FAST][ACC_BITS-1:ACC_FRAC];
         ps_in  = acc_ff[AVG_PITCH_SLOW][ACC_BITS-1:ACC_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         cross_ff    <= '0;
         last_pos_ff <= 1'b0;
         sq_pend_ff  <= 1'b0;
         sum_ff      <= '0;
         acc_ff      <= '{default: '0};
      end else begin
         idx_ff      <= idx_in;
         cross_ff    <= cross_in;
         last_pos_ff <= last_pos_in;
         sq_pend_ff  <= sq_pend_in;
         sum_ff      <= sum_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff     <= sq_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      fcross_ff <= fcross_in;
      pmul_ff   <= pmul_in;
      pitch_ff  <= pitch_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      rms_ff    <= rms_in;
      lf_ff     <= lf_in;
      ls_ff     <= ls_in;
      co_ff     <= co_in;
      pf_ff     <= pf_in;
      ps_ff     <= ps_in;
   end

   assign rms_level      = rms_ff;
   assign level_fast     = lf_ff;
   assign level_slow     = ls_ff;
   assign crossing_count = co_ff;
   assign pitch_fast     = pf_ff;
   assign pitch_slow     = ps_ff;

endmodule

[rtl/core/alpm_ctrl.sv]
// ----------------------------------------------------------------------------
// Audio level and pitch meter controller
// Sequences accumulation, end of frame work and the response register.
// ----------------------------------------------------------------------------
`include "audio_level_and_pitch_meter_defines.svh"

module alpm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  alpm_pkg::status_type   status,
   output alpm_pkg::cmd_type      cmd
);
   import alpm_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   avg_sel_type           sel_ff, sel_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_ACCUM);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      sel_in      = sel_ff;
      cmd         = '0;
      cmd.avg_sel = sel_ff;

      unique case (state_ff)
         ST_ACCUM: begin
            cmd.accept = req_valid;
            if (req_valid && status.frame_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == CNT_BITS'(ROOT_BITS - 1)) begin
               sel_in   = AVG_LEVEL_FAST;
               state_in = ST_AVG_MUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_AVG_MUL: begin
            cmd.avg_mul = 1'b1;
            state_in    = ST_AVG_ADD;
         end
         ST_AVG_ADD: begin
            cmd.avg_add = 1'b1;
            if (sel_ff == AVG_PITCH_SLOW) begin
               state_in = ST_OUTPUT;
            end else begin
               sel_in   = avg_sel_type'(sel_ff + 1'b1);
               state_in = ST_AVG_MUL;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         cnt_ff       <= '0;
         sel_ff       <= AVG_LEVEL_FAST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ALPM_ASSERT(a_frame_end_stalls, clock, reset, (cmd.accept && status.frame_end) |=> !req_ready)
   `ALPM_ASSERT(a_load_free_slot, clock, reset, cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
   `ALPM_ASSERT(a_sqrt_count, clock, reset, (state_ff == ST_SQRT) |-> (cnt_ff < CNT_BITS'(ROOT_BITS)))
   `ALPM_ASSERT(a_valid_from_load, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.out_load))
   `ALPM_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_ACCUM && !rsp_valid_ff))

endmodule

[test/alpm_checker.sv]
// ----------------------------------------------------------------------------
// Audio level and pitch meter checker
// Watches the sample, result and register ports, keeps its own copy of the
// meter state, predicts one frame report per completed frame and compares
// every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module alpm_checker
   import alpm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   alpm_req_if                      req_ch,
   alpm_rsp_if                      rsp_ch,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   input  logic                     pready,
   output int unsigned              mismatches,
   output int unsigned              outstanding
);

   localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_BITS) - 64'd1;

   typedef struct {
      logic [OUT_BITS-1:0]   rms_level;
      logic [OUT_BITS-1:0]   level_fast;
      logic [OUT_BITS-1:0]   level_slow;
      logic [CROSS_BITS-1:0] crossing_count;
      logic [OUT_BITS-1:0]   pitch_fast;
      logic [OUT_BITS-1:0]   pitch_slow;
   } frame_report_type;

   frame_report_type expected_reports[$];

   logic [LG_BITS-1:0]     cfg_frame_log2;
   logic [RATE_BITS-1:0]   cfg_rate;
   logic [WEIGHT_BITS-1:0] cfg_fast_w;
   logic [WEIGHT_BITS-1:0] cfg_slow_w;

   logic [SUM_BITS-1:0]   square_total;
   logic [CROSS_BITS-1:0] crossings_seen;
   logic [IDX_BITS-1:0]   frame_pos;
   logic                  was_positive;
   logic [ACC_BITS-1:0]   level_fast_q;
   logic [ACC_BITS-1:0]   level_slow_q;
   logic [ACC_BITS-1:0]   pitch_fast_q;
   logic [ACC_BITS-1:0]   pitch_slow_q;

   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned root;
      longint unsigned cand;
      root = 0;
      for (int b = ROOT_BITS; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= x) root = cand;
      end
      return root;
   endfunction

   // rounded blend of a Q16.8 average toward a new integer value
   function automatic logic [ACC_BITS-1:0] ema_update(input logic [ACC_BITS-1:0] acc,
                                                      input logic [WEIGHT_BITS-1:0] w,
                                                      input longint unsigned x);
      longint unsigned wl;
      longint unsigned t;
      wl = 64'(w);
      t = (64'd65536 - wl) * 64'(acc) + wl * (x << ACC_FRAC) + 64'd32768;
      return t[WEIGHT_BITS +: ACC_BITS];
   endfunction

   task automatic take_sample(input sample_type s);
      longint unsigned mag;
      longint unsigned total;
      longint unsigned frame_len;
      longint unsigned rms;
      longint unsigned pitch;
      int unsigned lg;
      frame_report_type rep;
      lg = cfg_frame_log2;
      if (lg < MIN_FRAME_LOG2) lg = MIN_FRAME_LOG2;
      if (lg > MAX_FRAME_LOG2) lg = MAX_FRAME_LOG2;
      frame_len = 64'd1 << lg;
      mag = (s < 0) ? 64'(-int'(s)) : 64'(int'(s));
      total = 64'(square_total) + mag * mag;
      if (total > SUM_LIMIT) total = SUM_LIMIT;
      square_total = total[SUM_BITS-1:0];
      if ((s > 0) != was_positive) crossings_seen = crossings_seen + 1'b1;
      was_positive = (s > 0);
      if (64'(frame_pos) < frame_len - 64'd1) begin
         frame_pos = frame_pos + 1'b1;
      end else begin
         rms = floor_root(64'(square_total) >> lg);
         pitch = (64'(crossings_seen) * 64'(cfg_rate)) >> (lg + 1);
         level_fast_q = ema_update(level_fast_q, cfg_fast_w, rms);
         level_slow_q = ema_update(level_slow_q, cfg_slow_w, rms);
         pitch_fast_q = ema_update(pitch_fast_q, cfg_fast_w, pitch);
         pitch_slow_q = ema_update(pitch_slow_q, cfg_slow_w, pitch);
         rep.rms_level      = rms[OUT_BITS-1:0];
         rep.level_fast     = level_fast_q[ACC_BITS-1:ACC_FRAC];
         rep.level_slow     = level_slow_q[ACC_BITS-1:ACC_FRAC];
         rep.crossing_count = crossings_seen;
         rep.pitch_fast     = pitch_fast_q[ACC_BITS-1:ACC_FRAC];
         rep.pitch_slow     = pitch_slow_q[ACC_BITS-1:ACC_FRAC];
         expected_reports = {expected_reports, rep};
         square_total   = '0;
         crossings_seen = '0;
         frame_pos      = '0;
      end
   endtask

   task automatic check_field(input string label, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t %s: expected %0d, actual %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      frame_report_type want;
      if (reset) begin
         cfg_frame_log2 = LG_BITS'(RESET_FRAME_LEN_LOG2);
         cfg_rate       = RATE_BITS'(RESET_SAMPLE_RATE);
         cfg_fast_w     = WEIGHT_BITS'(RESET_FAST_WEIGHT);
         cfg_slow_w     = WEIGHT_BITS'(RESET_SLOW_WEIGHT);
         square_total   = '0;
         crossings_seen = '0;
         frame_pos      = '0;
         was_positive   = 1'b0;
         level_fast_q   = '0;
         level_slow_q   = '0;
         pitch_fast_q   = '0;
         pitch_slow_q   = '0;
         expected_reports.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t unexpected result: rms_level %0d", $time, rsp_ch.rms_level);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               check_field("rms_level", want.rms_level, rsp_ch.rms_level);
               check_field("level_fast", want.level_fast, rsp_ch.level_fast);
               check_field("level_slow", want.level_slow, rsp_ch.level_slow);
               check_field("crossing_count", want.crossing_count, rsp_ch.crossing_count);
               check_field("pitch_fast", want.pitch_fast, rsp_ch.pitch_fast);
               check_field("pitch_slow", want.pitch_slow, rsp_ch.pitch_slow);
            end
         end
         if (req_ch.valid && req_ch.ready) take_sample(req_ch.sample);
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[3:2]))
               REG_FRAME_LEN_LOG2: cfg_frame_log2 = pwdata[LG_BITS-1:0];
               REG_SAMPLE_RATE:    cfg_rate       = pwdata[RATE_BITS-1:0];
               REG_FAST_WEIGHT:    cfg_fast_w     = pwdata[WEIGHT_BITS-1:0];
               REG_SLOW_WEIGHT:    cfg_slow_w     = pwdata[WEIGHT_BITS-1:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_reports.size();
   end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Audio level and pitch meter testbench
// Drives audio samples with random gaps, stalls the result side at random
// and rewrites the registers between phases: reset settings, a short
// directed frame of extreme samples, then random phases that also change
// the frame length in the middle of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import alpm_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 900;
   localparam int DRAIN_CYCLES = 40;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned quiet_cycles;
   bit          tone_neg;

   sample_type edge_samples [20] = '{
      16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF,
      16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF,
      16'h0001, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
      16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000
   };

   alpm_req_if req_ch ();
   alpm_rsp_if rsp_ch ();

   audio_level_and_pitch_meter DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   alpm_checker meter_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 15);
      return $urandom_range(30, 90);
   endfunction

   function automatic sample_type random_sample();
      int unsigned r;
      int mag;
      r = $urandom_range(0, 99);
      if (r < 8) return 16'h7FFF;
      if (r < 16) return 16'h8000;
      if (r < 24) return 16'h0000;
      if (r < 30) return sample_type'(int'($urandom_range(0, 2)) - 1);
      if (r < 60) begin
         // tone-like sign pattern
         if ($urandom_range(0, 3) != 0) tone_neg = !tone_neg;
         mag = $urandom_range(1, 32767);
         return sample_type'(tone_neg ? -mag : mag);
      end
      return sample_type'($urandom_range(0, 65535));
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_frame_log2();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(0, MIN_FRAME_LOG2 - 1);
      if (r < 85) return $urandom_range(MIN_FRAME_LOG2, 6);
      if (r < 95) return 7;
      return $urandom_range(MAX_FRAME_LOG2 + 1, 15);
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_rate();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 20) return 8000;
      if (r < 40) return 96000;
      return $urandom_range(8000, 96000);
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_weight();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return 0;
      if (r < 30) return 65535;
      if (r < 45) return $urandom_range(1, 8000);
      return $urandom_range(0, 65535);
   endfunction

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic push_sample(input sample_type s, input bit calm);
      int gap;
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int sent;
      int n;
      bit calm;
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.sample <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // one full frame under the reset settings
      repeat (1 << RESET_FRAME_LEN_LOG2) push_sample(random_sample(), 1'b0);
      wait_drained();

      // undersized length acts as the shortest frame; extreme weights and rate
      csr_write(REG_FRAME_LEN_LOG2, 0);
      csr_write(REG_SAMPLE_RATE, 8000);
      csr_write(REG_FAST_WEIGHT, 65535);
      csr_write(REG_SLOW_WEIGHT, 0);
      foreach (edge_samples[i]) push_sample(edge_samples[i], 1'b0);
      wait_drained();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 1)) csr_write(REG_FRAME_LEN_LOG2, pick_frame_log2());
         if ($urandom_range(0, 1)) csr_write(REG_SAMPLE_RATE, pick_rate());
         if ($urandom_range(0, 1)) csr_write(REG_FAST_WEIGHT, pick_weight());
         if ($urandom_range(0, 1)) csr_write(REG_SLOW_WEIGHT, pick_weight());
         n = $urandom_range(20, 160);
         calm = ($urandom_range(0, 3) == 0);
         repeat (n) push_sample(random_sample(), calm);
         sent += n;
         wait_drained();
      end

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      int run;
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
         rsp_ch.ready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = idle_len();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
